// ===== design/dltp_pkg.sv =====
// Package with the shared types and constants of the DLT standard header parser.
package dltp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_INCOMPLETE  = 2'd1,
        ST_BAD_VERSION = 2'd2
    } status_t;

    // Bit positions of the flags inside the header type byte.
    localparam int unsigned FLAG_ECU_BIT = 2;
    localparam int unsigned FLAG_SES_BIT = 3;
    localparam int unsigned FLAG_TMS_BIT = 4;

    // Header sizes in bytes.
    localparam logic [4:0] BASE_SIZE = 5'd4;
    localparam logic [4:0] OPT_SIZE  = 5'd4;

    // Versions at or above this limit are not supported.
    localparam logic [2:0] VERS_LIMIT = 3'd2;

    // One decoded header result.
    typedef struct packed {
        status_t     status;
        logic [7:0]  header_type;
        logic [7:0]  message_counter;
        logic [15:0] message_length;
        logic [31:0] ecu_id;
        logic [31:0] session_id;
        logic [31:0] timestamp;
        logic [4:0]  header_size;
    } result_t;

endpackage

// ===== design/dltp_byte_if.sv =====
// Interface of the input byte channel.
interface dltp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_data;

    modport source (output valid, output data_byte, output first_byte, output end_of_data,
                    input ready);
    modport sink (input valid, input data_byte, input first_byte, input end_of_data,
                  output ready);
endinterface

// ===== design/dltp_result_if.sv =====
// Interface of the header result channel.
interface dltp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  header_type;
    logic [7:0]  message_counter;
    logic [15:0] message_length;
    logic [31:0] ecu_id;
    logic [31:0] session_id;
    logic [31:0] timestamp;
    logic [4:0]  header_size;

    modport source (output valid, output status, output header_type, output message_counter,
                    output message_length, output ecu_id, output session_id,
                    output timestamp, output header_size, input ready);
    modport sink (input valid, input status, input header_type, input message_counter,
                  input message_length, input ecu_id, input session_id,
                  input timestamp, input header_size, output ready);
endinterface

// ===== design/dltp_out_buf.sv =====
// Two-entry output buffer (result register plus skid register) for header results.
module dltp_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    input  dltp_pkg::result_t push_data,
    output logic             push_ready,
    dltp_result_if.source    result
);
    import dltp_pkg::*;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;
    logic    pop;

    // New data is taken as long as the skid register is free.
    assign push_ready = !skid_valid_reg;
    assign pop        = main_valid_reg && result.ready;

    // Control state of the two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push_valid)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            main_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload of the two entries.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push_valid)
        begin
            if (!main_valid_reg || pop)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

    // Drive the result channel from the result register.
    assign result.valid           = main_valid_reg;
    assign result.status          = main_reg.status;
    assign result.header_type     = main_reg.header_type;
    assign result.message_counter = main_reg.message_counter;
    assign result.message_length  = main_reg.message_length;
    assign result.ecu_id          = main_reg.ecu_id;
    assign result.session_id      = main_reg.session_id;
    assign result.timestamp       = main_reg.timestamp;
    assign result.header_size     = main_reg.header_size;

endmodule

// ===== design/dlt_standard_header_parser.sv =====
// Top level of the DLT standard header parser.
//
//  Channel  Dir  Payload                                         Transaction
//  data     in   data_byte, first_byte, end_of_data              one message byte
//  result   out  status, header_type, message_counter,           one header result
//                message_length, ecu_id, session_id,
//                timestamp, header_size
//
// A byte is taken while the output buffer has a free entry; a byte that completes or
// ends a header puts its result into the output buffer at the same clock edge.
// A two-entry output buffer lets bytes keep flowing while one result waits; input
// stalls only when both entries are occupied. Reset clears the parser to idle and
// empties the output buffer.
module dlt_standard_header_parser (
    input  logic          clk,
    input  logic          rst_n,
    dltp_byte_if.sink     data,
    dltp_result_if.source result
);
    import dltp_pkg::*;

    logic [4:0]  byte_position_reg, byte_position_next;
    logic [4:0]  expected_size_reg, expected_size_next;
    logic [7:0]  header_type_reg, header_type_next;
    logic [7:0]  counter_reg, counter_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] ecu_reg, ecu_next;
    logic [31:0] session_reg, session_next;
    logic [31:0] time_reg, time_next;
    logic        active_reg, active_next;

    logic        accept;
    logic        push_ready;
    logic        res_valid;
    result_t     res;

    logic [4:0]  pos_inc;
    logic [1:0]  seg;
    logic [1:0]  ses_seg;
    logic [1:0]  tms_seg;
    logic        has_ecu;
    logic        has_ses;
    logic        has_tms;
    logic [4:0]  new_size;

    assign data.ready = push_ready;
    assign accept     = data.valid && push_ready;

    // Flags of the header in progress and the optional field a byte belongs to.
    assign has_ecu = header_type_reg[FLAG_ECU_BIT];
    assign has_ses = header_type_reg[FLAG_SES_BIT];
    assign has_tms = header_type_reg[FLAG_TMS_BIT];
    assign pos_inc = byte_position_reg + 5'd1;
    assign seg     = 2'((byte_position_reg - BASE_SIZE) >> 2);
    assign ses_seg = {1'b0, has_ecu};
    assign tms_seg = 2'({1'b0, has_ecu} + {1'b0, has_ses});

    // Header size announced by an incoming header type byte.
    assign new_size = BASE_SIZE
                    + (data.data_byte[FLAG_ECU_BIT] ? OPT_SIZE : 5'd0)
                    + (data.data_byte[FLAG_SES_BIT] ? OPT_SIZE : 5'd0)
                    + (data.data_byte[FLAG_TMS_BIT] ? OPT_SIZE : 5'd0);

    // Next parser state and the result caused by the accepted byte.
    always_comb
    begin
        byte_position_next = byte_position_reg;
        expected_size_next = expected_size_reg;
        header_type_next   = header_type_reg;
        counter_next       = counter_reg;
        length_next        = length_reg;
        ecu_next           = ecu_reg;
        session_next       = session_reg;
        time_next          = time_reg;
        active_next        = active_reg;
        res_valid          = 1'b0;
        res                = '0;
        res.status         = ST_OK;

        if (accept)
        begin
            if (data.first_byte)
            begin
                header_type_next   = data.data_byte;
                counter_next       = '0;
                length_next        = '0;
                ecu_next           = '0;
                session_next       = '0;
                time_next          = '0;
                byte_position_next = 5'd1;
                expected_size_next = new_size;
                res.header_type    = data.data_byte;
                if (data.data_byte[7:5] >= VERS_LIMIT)
                begin
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    res.status  = ST_BAD_VERSION;
                end
                else if (data.end_of_data)
                begin
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    res.status  = ST_INCOMPLETE;
                end
                else
                begin
                    active_next = 1'b1;
                end
            end
            else if (active_reg)
            begin
                // Shift the byte into the field that covers this position.
                if (byte_position_reg == 5'd1)
                begin
                    counter_next = data.data_byte;
                end
                else if (byte_position_reg < BASE_SIZE)
                begin
                    length_next = {length_reg[7:0], data.data_byte};
                end
                else if (has_ecu && seg == 2'd0)
                begin
                    ecu_next = {ecu_reg[23:0], data.data_byte};
                end
                else if (has_ses && seg == ses_seg)
                begin
                    session_next = {session_reg[23:0], data.data_byte};
                end
                else if (has_tms && seg == tms_seg)
                begin
                    time_next = {time_reg[23:0], data.data_byte};
                end
                byte_position_next = pos_inc;
                res.header_type    = header_type_reg;

                if (pos_inc >= expected_size_reg)
                begin
                    active_next         = 1'b0;
                    res_valid           = 1'b1;
                    res.status          = ST_OK;
                    res.message_counter = counter_next;
                    res.message_length  = length_next;
                    res.ecu_id          = ecu_next;
                    res.session_id      = session_next;
                    res.timestamp       = time_next;
                    res.header_size     = pos_inc;
                end
                else if (data.end_of_data)
                begin
                    active_next = 1'b0;
                    res_valid   = 1'b1;
                    res.status  = ST_INCOMPLETE;
                end
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            expected_size_reg <= '0;
            header_type_reg   <= '0;
            counter_reg       <= '0;
            length_reg        <= '0;
            ecu_reg           <= '0;
            session_reg       <= '0;
            time_reg          <= '0;
            active_reg        <= 1'b0;
        end
        else
        begin
            byte_position_reg <= byte_position_next;
            expected_size_reg <= expected_size_next;
            header_type_reg   <= header_type_next;
            counter_reg       <= counter_next;
            length_reg        <= length_next;
            ecu_reg           <= ecu_next;
            session_reg       <= session_next;
            time_reg          <= time_next;
            active_reg        <= active_next;
        end
    end

    // Result register with skid entry.
    dltp_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_data  (res),
        .push_ready (push_ready),
        .result     (result)
    );

endmodule
